// ===== design/cpic_pkg.sv =====
// shared types and constants of the circulation pump interval controller
package cpic_pkg;

	// register indexes of the configuration port
	typedef enum logic [2:0] {
		REG_NOMINAL_THRESHOLD = 3'd0,
		REG_HYSTERESIS        = 3'd1,
		REG_INTERVAL_SECONDS  = 3'd2,
		REG_DURATION_SECONDS  = 3'd3,
		REG_MAX_RUN_SECONDS   = 3'd4
	} reg_index_t;

	// reason codes of a switch command
	typedef enum logic [1:0] {
		CAUSE_INTERVAL_START = 2'd0,
		CAUSE_INTERVAL_STOP  = 2'd1,
		CAUSE_BELOW_THRESH   = 2'd2,
		CAUSE_MAX_RUN_OFF    = 2'd3
	} cause_t;

	// source codes of an update
	localparam logic SRC_TEMPERATURE = 1'b0;
	localparam logic SRC_PUMP        = 1'b1;

	localparam logic [1:0] SEEN_ALL = 2'b11;

	// register reset values
	localparam logic [10:0] RST_NOMINAL_THRESHOLD = 11'd650;
	localparam logic [7:0]  RST_HYSTERESIS        = 8'd5;
	localparam logic [15:0] RST_INTERVAL_SECONDS  = 16'd1200;
	localparam logic [15:0] RST_DURATION_SECONDS  = 16'd180;
	localparam logic [15:0] RST_MAX_RUN_SECONDS   = 16'd1200;

	// one switch command
	typedef struct packed {
		logic   on;
		cause_t cause;
	} cmd_t;

	// commands caused by one update, one or two of them
	typedef struct packed {
		logic two;
		cmd_t c0;
		cmd_t c1;
	} entry_t;

	// configuration write bundle
	typedef struct packed {
		logic       valid;
		reg_index_t index;
		logic [15:0] data;
	} cfg_wr_t;

endpackage

// ===== design/circulation_pump_interval_control.sv =====
// An update's first command passes the capture stage, the queue and the output register.
// The front takes one update per cycle while the queue has room; the output moves one
// command per cycle while out_ready is high, sending an update's two commands in turn.
// The evaluation stage updates the controller state once per update as it leaves capture.
// Reset: asynchronous, clears control state and loads the register defaults.
module circulation_pump_interval_control #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [15:0]       cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              source_id,
	input  logic signed [15:0] water_temp,
	input  logic              pump_running,
	input  logic [31:0]       now_seconds,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              switch_on,
	output logic [1:0]        cause,
	output logic              last_of_run
);

	cpic_pkg::cfg_wr_t cfg;
	logic              push_valid, push_ready;
	cpic_pkg::entry_t  push_entry;
	logic              pop_valid, pop_ready;
	cpic_pkg::entry_t  pop_entry;

	// register writes are always taken
	assign cfg_ready = 1'b1;
	assign cfg.valid = cfg_valid;
	assign cfg.index = cpic_pkg::reg_index_t'(cfg_index);
	assign cfg.data  = cfg_data;

	cpic_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.source_id    (source_id),
		.water_temp   (water_temp),
		.pump_running (pump_running),
		.now_seconds  (now_seconds),
		.push_valid   (push_valid),
		.push_entry   (push_entry),
		.push_ready   (push_ready)
	);

	cpic_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_entry (push_entry),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_entry  (pop_entry),
		.pop_ready  (pop_ready)
	);

	cpic_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (pop_valid),
		.q_entry     (pop_entry),
		.q_ready     (pop_ready),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.switch_on   (switch_on),
		.cause       (cause),
		.last_of_run (last_of_run)
	);

endmodule

// ===== design/cpic_queue.sv =====
// short command queue between the evaluation front and the output back
module cpic_queue #(
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	input  cpic_pkg::entry_t push_entry,
	output logic             push_ready,
	output logic             pop_valid,
	output cpic_pkg::entry_t pop_entry,
	input  logic             pop_ready
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	cpic_pkg::entry_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic do_push, do_pop;

	assign push_ready = (count_q != FULL_CNT);
	assign pop_valid  = (count_q != '0);
	assign pop_entry  = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== design/cpic_back.sv =====
// output side: serializes the queued commands onto the result channel
module cpic_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  cpic_pkg::entry_t q_entry,
	output logic             q_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             switch_on,
	output logic [1:0]       cause,
	output logic             last_of_run
);

	logic            out_valid_q;
	logic            pend_q;
	cpic_pkg::cmd_t  out_cmd_q;
	cpic_pkg::cmd_t  pend_cmd_q;
	logic            last_q;
	logic            free;

	assign free      = !out_valid_q || out_ready;
	assign q_ready   = free && !pend_q;
	assign out_valid = out_valid_q;
	assign switch_on = out_cmd_q.on;
	assign cause     = out_cmd_q.cause;
	assign last_of_run = last_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
		end else if (free) begin
			if (pend_q) begin
				out_valid_q <= 1'b1;
				pend_q      <= 1'b0;
			end else if (q_valid) begin
				out_valid_q <= 1'b1;
				pend_q      <= q_entry.two;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (free) begin
			if (pend_q) begin
				out_cmd_q <= pend_cmd_q;
				last_q    <= 1'b1;
			end else if (q_valid) begin
				out_cmd_q  <= q_entry.c0;
				last_q     <= !q_entry.two;
				pend_cmd_q <= q_entry.c1;
			end
		end
	end

endmodule

// ===== design/cpic_front.sv =====
// input side: takes updates, holds controller state and classifies commands
module cpic_front (
	input  logic              clk,
	input  logic              arst_n,
	input  cpic_pkg::cfg_wr_t cfg,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              source_id,
	input  logic signed [15:0] water_temp,
	input  logic              pump_running,
	input  logic [31:0]       now_seconds,
	output logic              push_valid,
	output cpic_pkg::entry_t  push_entry,
	input  logic              push_ready
);

	// configuration registers
	logic [10:0] nominal_q;
	logic [7:0]  hyst_q;
	logic [15:0] interval_q, duration_q, max_run_q;

	// controller state
	logic [1:0]         seen_q;
	logic [31:0]        last_on_q, run_start_q;
	logic signed [15:0] thr_q;
	logic               auto_q;

	// captured update
	logic               valid_s1;
	logic               src_s1;
	logic signed [15:0] temp_s1;
	logic               circ_s1;
	logic [31:0]        now_s1;

	logic               adv;
	logic               init, mask_done;
	logic [1:0]         mask_n;
	logic signed [15:0] thr0, thr_nom, thr_low, thr_n;
	logic [31:0]        run0, run1, run_n, last1, last_n;
	logic               auto0, auto_n;
	logic [16:0]        gap;
	logic [31:0]        since_on, d_run;
	logic               above, start_c, stop_c, below_c, below_emit, max_c;
	logic               run_restart;
	cpic_pkg::cmd_t     main_cmd, max_cmd;
	logic               main_v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nominal_q  <= cpic_pkg::RST_NOMINAL_THRESHOLD;
			hyst_q     <= cpic_pkg::RST_HYSTERESIS;
			interval_q <= cpic_pkg::RST_INTERVAL_SECONDS;
			duration_q <= cpic_pkg::RST_DURATION_SECONDS;
			max_run_q  <= cpic_pkg::RST_MAX_RUN_SECONDS;
		end else if (cfg.valid) begin
			case (cfg.index)
				cpic_pkg::REG_NOMINAL_THRESHOLD: nominal_q  <= cfg.data[10:0];
				cpic_pkg::REG_HYSTERESIS:        hyst_q     <= cfg.data[7:0];
				cpic_pkg::REG_INTERVAL_SECONDS:  interval_q <= cfg.data;
				cpic_pkg::REG_DURATION_SECONDS:  duration_q <= cfg.data;
				cpic_pkg::REG_MAX_RUN_SECONDS:   max_run_q  <= cfg.data;
				default: ;
			endcase
		end
	end

	// capture stage
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			src_s1  <= source_id;
			temp_s1 <= water_temp;
			circ_s1 <= pump_running;
			now_s1  <= now_seconds;
		end
	end

	// start-up tracking of both sources
	assign init      = (seen_q != cpic_pkg::SEEN_ALL);
	assign mask_n    = seen_q | ((src_s1 == cpic_pkg::SRC_PUMP) ? 2'b10 : 2'b01);
	assign mask_done = (mask_n == cpic_pkg::SEEN_ALL);

	assign thr_nom = $signed({5'b0, nominal_q});
	assign thr_low = $signed({5'b0, nominal_q} - {8'b0, hyst_q});
	assign thr0    = init ? thr_nom : thr_q;
	assign run0    = init ? '0 : run_start_q;
	assign auto0   = init ? 1'b0 : auto_q;

	// pump status bookkeeping
	assign last1 = circ_s1 ? now_s1 : last_on_q;
	assign run1  = circ_s1 ? ((run0 == '0) ? now_s1 : run0) : '0;

	// threshold and interval decisions
	assign above    = (temp_s1 >= thr0);
	assign gap      = {1'b0, interval_q} - {1'b0, duration_q};
	assign since_on = circ_s1 ? '0 : (now_s1 - last_on_q);
	assign d_run    = now_s1 - run1;
	assign start_c  = above && (gap[16] || (since_on > {16'b0, gap[15:0]}));
	assign stop_c   = above && !start_c && auto0 && (run1 != '0)
		&& (d_run > {16'b0, duration_q});
	assign below_c    = !above && auto0;
	assign below_emit = below_c && (circ_s1 || (last_on_q == now_s1));

	// a start with no run open opens one now, so its age is zero
	assign run_restart = start_c && (run1 == '0);
	assign run_n  = run_restart ? now_s1 : run1;
	assign last_n = start_c ? now_s1 : last1;
	assign max_c  = (run_n != '0)
		&& (run_restart ? (max_run_q == '0) : (d_run >= {16'b0, max_run_q}));

	always_comb begin
		thr_n  = thr0;
		auto_n = auto0;
		if (start_c) begin
			thr_n  = thr_low;
			auto_n = 1'b1;
		end else if (stop_c) begin
			auto_n = 1'b0;
		end else if (below_c) begin
			thr_n  = thr_nom;
			auto_n = 1'b0;
		end
	end

	// command list for the queue
	always_comb begin
		main_v         = start_c || stop_c || below_emit;
		main_cmd.on    = start_c;
		main_cmd.cause = start_c ? cpic_pkg::CAUSE_INTERVAL_START
			: (stop_c ? cpic_pkg::CAUSE_INTERVAL_STOP : cpic_pkg::CAUSE_BELOW_THRESH);
		max_cmd.on     = 1'b0;
		max_cmd.cause  = cpic_pkg::CAUSE_MAX_RUN_OFF;
		push_entry.two = main_v && max_c;
		push_entry.c0  = main_v ? main_cmd : max_cmd;
		push_entry.c1  = max_cmd;
	end

	assign push_valid = valid_s1 && !(init && !mask_done) && (main_v || max_c);
	assign adv        = valid_s1 && (!push_valid || push_ready);

	// state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q      <= '0;
			last_on_q   <= '0;
			run_start_q <= '0;
			thr_q       <= '0;
			auto_q      <= 1'b0;
		end else if (adv) begin
			if (init && !mask_done) begin
				seen_q <= mask_n;
			end else begin
				seen_q      <= cpic_pkg::SEEN_ALL;
				last_on_q   <= last_n;
				run_start_q <= run_n;
				thr_q       <= thr_n;
				auto_q      <= auto_n;
			end
		end
	end

endmodule
